FILE: hdl/serial_frame_and_line_splitter_assert.svh
// Assertion macros shared by the splitter modules
`ifndef SERIAL_FRAME_AND_LINE_SPLITTER_ASSERT_SVH
`define SERIAL_FRAME_AND_LINE_SPLITTER_ASSERT_SVH

// Checked only out of reset
`define SFLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define SFLS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sfls_pkg.sv
package sfls_pkg;

    // Received byte values
    localparam logic [7:0] BYTE_T   = 8'h54;
    localparam logic [7:0] BYTE_F   = 8'h46;
    localparam logic [7:0] BYTE_VER = 8'h01;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    // Result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_LINE_END  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd2;
    localparam logic [1:0] KIND_FRAME_END = 2'd3;

    // Frame byte positions; payload and check byte from POS_PAYLOAD on
    localparam logic [10:0] POS_IDLE    = 11'd0;
    localparam logic [10:0] POS_HDR_F   = 11'd1;
    localparam logic [10:0] POS_VER     = 11'd2;
    localparam logic [10:0] POS_CMD     = 11'd3;
    localparam logic [10:0] POS_LEN_LO  = 11'd4;
    localparam logic [10:0] POS_LEN_HI  = 11'd5;
    localparam logic [10:0] POS_PAYLOAD = 11'd6;
    localparam logic [10:0] POS_MAX     = 11'd2046;

    // Hard ceiling on the payload length
    localparam logic [10:0] PAYLOAD_CAP = 11'd2040;

    // Register map (word index) and reset values
    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_MAX_LINE    = 1'b1;
    localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1800;
    localparam logic [7:0]  MAX_LINE_RST    = 8'd159;

    typedef struct packed {
        logic [10:0] max_payload;
        logic [7:0]  max_line;
    } t_cfg;

    typedef struct packed {
        logic        vld;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [7:0]  command;
        logic [10:0] count;
    } t_result;

endpackage

FILE: hdl/sfls_cfg.sv
module sfls_cfg
    import sfls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output t_cfg        o_cfg
);

    logic [10:0] r_max_payload;
    logic [7:0]  r_max_line;
    logic        wr_en;

    // Access phase of a write request; the port never waits
    assign wr_en = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_max_line    <= MAX_LINE_RST;
        end else if (wr_en) begin
            if (i_paddr[2] == REG_MAX_PAYLOAD) begin
                r_max_payload <= i_pwdata[10:0];
            end else begin
                r_max_line <= i_pwdata[7:0];
            end
        end
    end

    // Read back
    always_comb begin
        if (i_paddr[2] == REG_MAX_LINE) begin
            o_prdata = {24'd0, r_max_line};
        end else begin
            o_prdata = {21'd0, r_max_payload};
        end
    end

    assign o_cfg.max_payload = r_max_payload;
    assign o_cfg.max_line    = r_max_line;

endmodule

FILE: hdl/sfls_core.sv
`include "serial_frame_and_line_splitter_assert.svh"

module sfls_core
    import sfls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    logic [10:0] r_pos,  n_pos;
    logic [7:0]  r_shb,  n_shb;
    logic [7:0]  r_cmd,  n_cmd;
    logic [15:0] r_len,  n_len;
    logic [7:0]  r_line, n_line;
    logic [10:0] limit;
    logic [10:0] idx;

    // Byte decode and state update
    always_comb begin
        n_pos  = r_pos;
        n_shb  = r_shb;
        n_cmd  = r_cmd;
        n_len  = r_len;
        n_line = r_line;
        o_res  = '0;
        limit  = (i_cfg.max_payload < PAYLOAD_CAP) ? i_cfg.max_payload : PAYLOAD_CAP;
        idx    = r_pos - POS_PAYLOAD;

        case (r_pos)
            POS_IDLE: begin
                if (i_byte == BYTE_T) begin
                    n_pos = POS_HDR_F;
                end else if (i_byte == BYTE_CR) begin
                    // carriage return dropped
                end else if (i_byte == BYTE_LF) begin
                    o_res.vld   = 1'b1;
                    o_res.kind  = KIND_LINE_END;
                    o_res.count = {3'd0, r_line};
                    n_line      = '0;
                end else if (r_line < i_cfg.max_line) begin
                    o_res.vld   = 1'b1;
                    o_res.kind  = KIND_CHAR;
                    o_res.data  = i_byte;
                    o_res.count = {3'd0, r_line};
                    n_line      = r_line + 8'd1;
                end
            end
            POS_HDR_F: begin
                n_shb = i_byte;
                n_pos = POS_VER;
            end
            POS_VER: begin
                // bad marker or version: drop the frame, keep the line
                if (r_shb != BYTE_F || i_byte != BYTE_VER) begin
                    n_pos = POS_IDLE;
                end else begin
                    n_pos = POS_CMD;
                end
            end
            POS_CMD: begin
                n_cmd = i_byte;
                n_pos = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                n_len = {8'd0, i_byte};
                n_pos = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                n_len = {i_byte, r_len[7:0]};
                n_pos = POS_PAYLOAD;
            end
            default: begin
                if (r_pos == POS_PAYLOAD && r_len > {5'd0, limit}) begin
                    // oversize frame dropped on its first payload byte
                    n_pos = POS_IDLE;
                end else if ({5'd0, idx} < r_len) begin
                    o_res.vld     = 1'b1;
                    o_res.kind    = KIND_PAYLOAD;
                    o_res.data    = i_byte;
                    o_res.command = r_cmd;
                    o_res.count   = idx;
                    n_pos         = r_pos + 11'd1;
                end else begin
                    // check byte, passed on unverified
                    o_res.vld     = 1'b1;
                    o_res.kind    = KIND_FRAME_END;
                    o_res.data    = i_byte;
                    o_res.command = r_cmd;
                    o_res.count   = r_len[10:0];
                    n_pos         = POS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_IDLE;
            r_shb  <= '0;
            r_cmd  <= '0;
            r_len  <= '0;
            r_line <= '0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_shb  <= n_shb;
            r_cmd  <= n_cmd;
            r_len  <= n_len;
            r_line <= n_line;
        end
    end

    `SFLS_ASSERT(a_pos_bound, i_clk, i_rst_n, (r_pos <= POS_MAX), "frame position out of range")
    `SFLS_ASSERT(a_len_checked, i_clk, i_rst_n, (r_pos > POS_PAYLOAD |-> r_len <= {5'd0, PAYLOAD_CAP}), "payload under way with oversize length")
    `SFLS_ASSERT(a_line_limit, i_clk, i_rst_n, (i_en && o_res.vld && o_res.kind == KIND_CHAR |-> o_res.count < {3'd0, i_cfg.max_line}), "line character past line limit")

endmodule

FILE: hdl/serial_frame_and_line_splitter.sv
// Serial frame and line splitter. Takes one received byte per request and splits
// the stream into text lines (characters, then a line end with its length; CR is
// dropped, characters past max_line are dropped) and binary frames starting 'T','F',
// 0x01, command, 16-bit little-endian length, payload, check byte. Frames with a bad
// header are dropped at their third byte, oversize ones at their seventh. Payload
// bytes come out with their index; the frame end carries the length and the check
// byte, which is not verified. One byte is accepted every cycle while the input side
// is not stalled; each byte passes an input register and then a result register. A
// stall on the result side holds the result register and then the input register;
// the input side stalls only when both are full.
`include "serial_frame_and_line_splitter_assert.svh"

module serial_frame_and_line_splitter
    import sfls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [7:0]  o_command,
    output logic [10:0] o_count,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_out_vld;
    t_result     r_out;
    logic        out_free;
    logic        step;
    t_cfg        cfg;
    t_result     res;

    assign pready = 1'b1;

    sfls_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // Flow control: the input stage moves whenever the result register can load
    assign out_free = !r_out_vld || !i_stall;
    assign step     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;

    // Input register: loads when empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfls_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= step && res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= res;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_kind    = r_out.kind;
    assign o_data    = r_out.data;
    assign o_command = r_out.command;
    assign o_count   = r_out.count;

    `SFLS_ASSERT_ALWAYS(a_rst_empty, i_clk, (!i_rst_n |=> !o_valid && !o_stall), "pipeline not empty after reset")
    `SFLS_ASSERT(a_stall_cause, i_clk, i_rst_n, (o_stall |-> r_in_vld && o_valid && i_stall), "input stalled without a blocked result")
    `SFLS_ASSERT(a_line_end_clean, i_clk, i_rst_n, (o_valid && o_kind == KIND_LINE_END |-> o_data == 8'd0 && o_command == 8'd0), "line end carries data")

endmodule
